// ----- src/ffsa_pkg.sv -----
`timescale 1ns / 1ps
package ffsa_pkg;

	localparam int LEN_W = 17;
	localparam int K_W   = 10;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_BADREL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_SETFREE,
		CMD_TAKE,
		CMD_SPLIT,
		CMD_MERGE
	} cmd_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALIGN,
		S_SCAN,
		S_ACALC,
		S_AWR,
		S_MERGE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             valid;
		logic             free;
		logic [15:0]      start;
		logic [LEN_W-1:0] len;
	} entry_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [K_W-1:0]   k;
		logic [15:0]      new_start;
		logic [LEN_W-1:0] new_len;
		logic [LEN_W-1:0] alloc_len;
	} cmd_t;

	typedef struct packed {
		logic             kind;
		logic [LEN_W-1:0] aligned;
		logic [15:0]      off;
	} query_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] request_bytes;
		logic [15:0] release_offset;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] data_offset;
		logic [15:0] granted_bytes;
		logic        arena_empty;
	} out_item_t;

endpackage

// ----- src/first_fit_segment_allocator.sv -----
`timescale 1ns / 1ps
// first-fit segment allocator for one arena, kept as an address-ordered row of cells
// items: start with item while busy is low (kind 0 allocate, 1 release); busy stays
// high until the result is shown. result/done: one cycle strobe per item, the
// receiver cannot stall it and must take it in that cycle.
// cfg_we/cfg_wdata set min_split_bytes (reset 16); write only while busy is low, the block does not enforce it.
// allocate: the align pipeline rounds the size up, the first-fit scan then walks
// the table entry by entry (up to MAX_SEGMENTS), the hit is split or taken
// (S_ACALC, S_AWR), and S_DONE reports the result.
// release: the scan walks the entries, then each merge step joins the segment at
// base with the free segment after it, starting one back if the preceding one is free.
// a new item is taken the cycle the previous result strobes.
// reset: the table holds one free segment covering the arena, nothing is in flight.
module first_fit_segment_allocator #(
	parameter int ARENA_BYTES  = 65536,
	parameter int HEADER_BYTES = 32,
	parameter int ALIGN_BYTES  = 16,
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ffsa_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [12:0]         cfg_wdata,
	output logic                done,
	output ffsa_pkg::out_item_t result
);
	import ffsa_pkg::*;

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam logic [LEN_W-1:0] HDR = LEN_W'(HEADER_BYTES);

	state_t state_q, state_d;

	in_item_t          item_q;
	logic [LEN_W-1:0]  aligned_q;
	logic [MAX_SEGMENTS-1:0] token_q;
	logic [K_W-1:0]    idx_q;
	logic [K_W-1:0]    base_q;
	logic              prev_free_q;
	entry_t            hit_ent_q;
	logic [LEN_W-1:0]  rest_q;
	logic              can_split_q;
	status_t           status_q;
	logic [15:0]       offset_q;
	logic [15:0]       granted_q;
	logic [CNT_W-1:0]  total_q;
	logic [12:0]       min_split_q;
	out_item_t         result_q;
	logic              done_q;

	entry_t            ents [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] hits;
	entry_t            sel_ent;
	logic              sel_hit;
	logic              empty;
	cmd_t              cmd;
	query_t            query;
	logic              do_split;
	logic [LEN_W-1:0]  gr_len;
	logic              accept;
	logic              al_done;
	logic [LEN_W-1:0]  al_value;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	ffsa_align #(.ALIGN_BYTES(ALIGN_BYTES)) u_align (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (accept && !item.kind),
		.req     (item.request_bytes),
		.done    (al_done),
		.aligned (al_value)
	);

	assign query.kind    = item_q.kind;
	assign query.aligned = aligned_q;
	assign query.off     = item_q.release_offset;

	for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
		entry_t l_ent;
		entry_t r_ent;
		if (j == 0) begin : g_first
			assign l_ent = '0;
		end else begin : g_mid_l
			assign l_ent = ents[j-1];
		end
		if (j == MAX_SEGMENTS - 1) begin : g_last
			assign r_ent = '0;
		end else begin : g_mid_r
			assign r_ent = ents[j+1];
		end
		ffsa_cell #(
			.IDX          (j),
			.HEADER_BYTES (HEADER_BYTES),
			.ARENA_BYTES  (ARENA_BYTES)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.query  (query),
			.left   (l_ent),
			.right  (r_ent),
			.entry  (ents[j]),
			.hit    (hits[j])
		);
	end

	// the cell under the token, and whether every segment is free
	always_comb begin
		sel_ent = '0;
		sel_hit = 1'b0;
		empty   = 1'b1;
		for (int j = 0; j < MAX_SEGMENTS; j++) begin
			if (token_q[j]) begin
				sel_ent = entry_t'(sel_ent | ents[j]);
				sel_hit = sel_hit | hits[j];
			end
			if (ents[j].valid && !ents[j].free) empty = 1'b0;
		end
	end

	assign do_split = (rest_q > (HDR + LEN_W'(min_split_q))) && can_split_q;
	assign gr_len   = do_split ? aligned_q : hit_ent_q.len;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = item.kind ? S_SCAN : S_ALIGN;
			S_ALIGN: if (al_done) state_d = S_SCAN;
			S_SCAN: begin
				if (!sel_ent.valid) state_d = S_DONE;
				else if (sel_hit) state_d = item_q.kind ? S_MERGE : S_ACALC;
			end
			S_ACALC: state_d = S_AWR;
			S_AWR:   state_d = S_DONE;
			S_MERGE: if (!(sel_ent.valid && sel_ent.free)) state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = CMD_NONE;
		cmd.new_start = 16'({1'b0, hit_ent_q.start} + aligned_q + HDR);
		cmd.new_len   = rest_q - HDR;
		cmd.alloc_len = aligned_q;
		unique case (state_q)
			S_SCAN: begin
				if (sel_ent.valid && sel_hit && item_q.kind) begin
					cmd.op = CMD_SETFREE;
					cmd.k  = idx_q;
				end
			end
			S_AWR: begin
				cmd.op = do_split ? CMD_SPLIT : CMD_TAKE;
				cmd.k  = base_q;
			end
			S_MERGE: begin
				if (sel_ent.valid && sel_ent.free) begin
					cmd.op = CMD_MERGE;
					cmd.k  = base_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= CNT_W'(1);
			min_split_q <= 13'd16;
			done_q      <= 1'b0;
			token_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			if (cfg_we) min_split_q <= cfg_wdata;
			if (accept) token_q <= MAX_SEGMENTS'(1);
			if (state_q == S_SCAN && sel_ent.valid) begin
				if (!sel_hit || (item_q.kind && !prev_free_q)) token_q <= token_q << 1;
			end
			if (state_q == S_AWR && do_split) total_q <= total_q + CNT_W'(1);
			if (cmd.op == CMD_MERGE) total_q <= total_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q      <= item;
			idx_q       <= '0;
			prev_free_q <= 1'b0;
			status_q    <= ST_DONE;
			offset_q    <= '0;
			granted_q   <= '0;
		end
		if (state_q == S_ALIGN && al_done) aligned_q <= al_value;
		if (state_q == S_SCAN) begin
			if (!sel_ent.valid) begin
				status_q <= item_q.kind ? ST_BADREL : ST_NOFIT;
			end else if (sel_hit) begin
				hit_ent_q <= sel_ent;
				base_q    <= (item_q.kind && prev_free_q) ? idx_q - K_W'(1) : idx_q;
			end else begin
				idx_q       <= idx_q + K_W'(1);
				prev_free_q <= sel_ent.free;
			end
		end
		if (state_q == S_ACALC) begin
			rest_q      <= hit_ent_q.len - aligned_q;
			can_split_q <= (total_q < CNT_W'(MAX_SEGMENTS));
		end
		if (state_q == S_AWR) begin
			offset_q  <= hit_ent_q.start;
			granted_q <= gr_len[LEN_W-1] ? 16'hFFFF : gr_len[15:0];
		end
		if (state_q == S_DONE) begin
			result_q.status        <= status_q;
			result_q.data_offset   <= offset_q;
			result_q.granted_bytes <= granted_q;
			result_q.arena_empty   <= empty;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != '0) else $error("segment count dropped to zero");
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_SEGMENTS)) else $error("segment count above table size");
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token_q)) else $error("scan token not one-hot");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item accepted but block not busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while still busy");

endmodule

// ----- src/ffsa_cell.sv -----
`timescale 1ns / 1ps
module ffsa_cell #(
	parameter int IDX          = 0,
	parameter int HEADER_BYTES = 32,
	parameter int ARENA_BYTES  = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffsa_pkg::cmd_t   cmd,
	input  ffsa_pkg::query_t query,
	input  ffsa_pkg::entry_t left,
	input  ffsa_pkg::entry_t right,
	output ffsa_pkg::entry_t entry,
	output logic           hit
);
	import ffsa_pkg::*;

	localparam logic [LEN_W-1:0] HDR = LEN_W'(HEADER_BYTES);
	localparam logic [K_W:0]     MY  = (K_W+1)'(IDX);

	entry_t ent_q;
	logic [K_W:0] k_ext;
	logic [K_W:0] k_nxt;

	assign k_ext = {1'b0, cmd.k};
	assign k_nxt = k_ext + (K_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if (IDX == 0) begin
				ent_q.valid <= 1'b1;
				ent_q.free  <= 1'b1;
				ent_q.start <= 16'(HEADER_BYTES);
				ent_q.len   <= LEN_W'(ARENA_BYTES - 2 * HEADER_BYTES);
			end else begin
				ent_q <= '0;
			end
		end else begin
			case (cmd.op)
				CMD_SETFREE: begin
					if (MY == k_ext) ent_q.free <= 1'b1;
				end
				CMD_TAKE: begin
					if (MY == k_ext) ent_q.free <= 1'b0;
				end
				CMD_SPLIT: begin
					if (MY == k_ext) begin
						ent_q.free <= 1'b0;
						ent_q.len  <= cmd.alloc_len;
					end else if (MY == k_nxt) begin
						ent_q.valid <= 1'b1;
						ent_q.free  <= 1'b1;
						ent_q.start <= cmd.new_start;
						ent_q.len   <= cmd.new_len;
					end else if (MY > k_nxt) begin
						ent_q <= left;
					end
				end
				CMD_MERGE: begin
					// absorb the right neighbor, everything behind it moves down one
					if (MY == k_ext) ent_q.len <= ent_q.len + HDR + right.len;
					else if (MY > k_ext) ent_q <= right;
				end
				default: ;
			endcase
		end
	end

	assign entry = ent_q;
	assign hit = query.kind ? (ent_q.valid && !ent_q.free && ({1'b0, ent_q.start} ==
		{1'b0, query.off}))
		: (ent_q.valid && ent_q.free && (ent_q.len >= query.aligned));

endmodule

// ----- src/ffsa_align.sv -----
`timescale 1ns / 1ps
module ffsa_align #(
	parameter int ALIGN_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [15:0] req,
	output logic        done,
	output logic [ffsa_pkg::LEN_W-1:0] aligned
);
	import ffsa_pkg::*;

	// floor(x / ALIGN_BYTES) as (x * RCP) >> SH, exact for every x below 2**LEN_W
	localparam int SH    = LEN_W + $clog2(ALIGN_BYTES);
	localparam int RCP_W = LEN_W + 1;
	localparam int PW    = LEN_W + RCP_W;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RECIP);
	localparam logic [LEN_W-1:0] AL  = LEN_W'(ALIGN_BYTES);

	logic [LEN_W-1:0] num_s1;
	logic [LEN_W-1:0] quo_s2;
	logic [LEN_W-1:0] al_s3;
	logic             vld_s1;
	logic             vld_s2;
	logic             vld_s3;
	logic [PW-1:0]    prod;

	assign prod = PW'(num_s1) * PW'(RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= go;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go) num_s1 <= LEN_W'(req) + LEN_W'(ALIGN_BYTES - 1);
		if (vld_s1) quo_s2 <= LEN_W'(prod >> SH);
		if (vld_s2) al_s3 <= quo_s2 * AL;
	end

	assign done    = vld_s3;
	assign aligned = al_s3;

endmodule
